[hw/rtl/vpnt_pkg.sv]
// ----------------------------------------------------------------------------
// vpnt_pkg
// Shared widths, register codes, reset values and stage sideband types for
// the vertex point/normal transform.
// ----------------------------------------------------------------------------
package vpnt_pkg;

  localparam int CoefW     = 16;  // Q3.12 coefficient
  localparam int InW       = 16;  // position / normal input
  localparam int ProdW     = 32;  // coef * input
  localparam int AccW      = 34;  // sum of three products
  localparam int FracBits  = 12;
  localparam int PosW      = 24;
  localparam int MagW      = 21;  // |n|, n rounded back to Q1.14
  localparam int SqW       = 2 * MagW;
  localparam int SumW      = SqW + 1;
  localparam int RootInW   = 64;  // S << 22 plus headroom for the trial add
  localparam int SqrtPre   = 22;
  localparam int SqrtSteps = 32;
  localparam int LenW      = 32;
  localparam int DenW      = LenW + 1;    // 2 * len
  localparam int NumShift  = 26;
  localparam int NumW      = MagW + NumShift;
  localparam int QW        = 16;          // quotient bits
  localparam int DivSteps  = QW;
  localparam int UnitW     = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int NormRowW  = 48;

  localparam logic signed [AccW-1:0] RoundBias = AccW'(2048);
  localparam logic [UnitW-1:0]       UnitOne   = UnitW'(16384);

  typedef enum logic [CfgIdxW-1:0] {
    REG_POINT0  = 3'd0,
    REG_POINT1  = 3'd1,
    REG_POINT2  = 3'd2,
    REG_NORMAL0 = 3'd3,
    REG_NORMAL1 = 3'd4,
    REG_NORMAL2 = 3'd5
  } vpnt_reg_t;

  localparam logic [CfgDataW-1:0] RowRst0 = 64'h0000_0000_0000_1000;
  localparam logic [CfgDataW-1:0] RowRst1 = 64'h0000_0000_1000_0000;
  localparam logic [CfgDataW-1:0] RowRst2 = 64'h0000_1000_0000_0000;

  typedef struct packed {
    logic [2:0][CfgDataW-1:0] point;
    logic [2:0][NormRowW-1:0] normal;
  } vpnt_cfg_t;

  // travels alongside each vertex through the pipe
  typedef struct packed {
    logic                 valid;
    logic [2:0][PosW-1:0] pos;
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 zero;
  } vpnt_side_t;

endpackage

[hw/rtl/vpnt_in_if.sv]
// ----------------------------------------------------------------------------
// vpnt_in_if
// Vertex request channel: position and normal.
// ----------------------------------------------------------------------------
interface vpnt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;

  modport source(output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
               output ready);
endinterface

[hw/rtl/vpnt_out_if.sv]
// ----------------------------------------------------------------------------
// vpnt_out_if
// Result channel: transformed position and unit normal.
// ----------------------------------------------------------------------------
interface vpnt_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic signed [23:0] out_z;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic               degenerate;

  modport source(output valid, out_x, out_y, out_z, unit_x, unit_y, unit_z,
                 degenerate, input ready);
  modport sink(input valid, out_x, out_y, out_z, unit_x, unit_y, unit_z,
               degenerate, output ready);
endinterface

[hw/rtl/vpnt_cfg_if.sv]
// ----------------------------------------------------------------------------
// vpnt_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface vpnt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/vpnt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// vpnt_cfg_regs
// Matrix register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module vpnt_cfg_regs import vpnt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  logic [CfgIdxW-1:0]  index,
  input  logic [CfgDataW-1:0] data,
  output vpnt_cfg_t           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point[0]  <= RowRst0;
      cfg.point[1]  <= RowRst1;
      cfg.point[2]  <= RowRst2;
      cfg.normal[0] <= RowRst0[NormRowW-1:0];
      cfg.normal[1] <= RowRst1[NormRowW-1:0];
      cfg.normal[2] <= RowRst2[NormRowW-1:0];
    end else if (wr) begin
      case (index)
        REG_POINT0:  cfg.point[0]  <= data;
        REG_POINT1:  cfg.point[1]  <= data;
        REG_POINT2:  cfg.point[2]  <= data;
        REG_NORMAL0: cfg.normal[0] <= data[NormRowW-1:0];
        REG_NORMAL1: cfg.normal[1] <= data[NormRowW-1:0];
        REG_NORMAL2: cfg.normal[2] <= data[NormRowW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/vpnt_xform.sv]
// ----------------------------------------------------------------------------
// vpnt_xform
// Four stages: products, sum/round/translate, squares, sum of squares.
// ----------------------------------------------------------------------------
module vpnt_xform import vpnt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [InW-1:0] px,
  input  logic signed [InW-1:0] py,
  input  logic signed [InW-1:0] pz,
  input  logic signed [InW-1:0] nx,
  input  logic signed [InW-1:0] ny,
  input  logic signed [InW-1:0] nz,
  input  vpnt_cfg_t             cfg,
  output vpnt_side_t            side,
  output logic [SumW-1:0]       sum
);

  logic signed [InW-1:0]   pin [3];
  logic signed [InW-1:0]   nin [3];
  logic                    v1;
  logic signed [ProdW-1:0] pp [3][3];
  logic signed [ProdW-1:0] np [3][3];
  logic signed [AccW-1:0]  acc [3];
  logic signed [AccW-1:0]  nacc [3];
  logic signed [AccW-1:0]  prnd [3];
  logic signed [AccW-1:0]  nrnd [3];
  vpnt_side_t              s2;
  vpnt_side_t              s2_next;
  vpnt_side_t              s3;
  vpnt_side_t              side_next;
  logic [SqW-1:0]          sq [3];
  logic [SumW-1:0]         sum_next;

  assign pin[0] = px;
  assign pin[1] = py;
  assign pin[2] = pz;
  assign nin[0] = nx;
  assign nin[1] = ny;
  assign nin[2] = nz;

  // stage 1: nine products per matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pp[r][c] <= $signed(cfg.point[r][CoefW*c +: CoefW]) * pin[c];
          np[r][c] <= $signed(cfg.normal[r][CoefW*c +: CoefW]) * nin[c];
        end
      end
    end
  end

  // stage 2: row sums, round-half-up shift, translation
  always_comb begin
    s2_next       = '0;
    s2_next.valid = v1;
    for (int r = 0; r < 3; r++) begin
      acc[r]  = AccW'(pp[r][0]) + AccW'(pp[r][1]) + AccW'(pp[r][2]);
      nacc[r] = AccW'(np[r][0]) + AccW'(np[r][1]) + AccW'(np[r][2]);
      prnd[r] = (acc[r] + RoundBias) >>> FracBits;
      nrnd[r] = (nacc[r] + RoundBias) >>> FracBits;
      s2_next.pos[r] = PosW'(prnd[r]) +
                       PosW'($signed(cfg.point[r][CfgDataW-1 -: CoefW]));
      s2_next.neg[r] = nrnd[r][AccW-1];
      s2_next.mag[r] = nrnd[r][AccW-1] ? MagW'(-nrnd[r]) : MagW'(nrnd[r]);
    end
  end

  assign sum_next = SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);

  always_comb begin
    side_next      = s3;
    side_next.zero = (sum_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid   <= 1'b0;
      s3.valid   <= 1'b0;
      side.valid <= 1'b0;
    end else if (en) begin
      s2   <= s2_next;
      s3   <= s2;
      side <= side_next;
    end
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sq[r] <= s2.mag[r] * s2.mag[r];   // stage 3
      end
      sum <= sum_next;                      // stage 4
    end
  end

endmodule

[hw/rtl/vpnt_isqrt.sv]
// ----------------------------------------------------------------------------
// vpnt_isqrt
// Digit-by-digit integer square root of S << 22, one result bit per stage.
// ----------------------------------------------------------------------------
module vpnt_isqrt import vpnt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  vpnt_side_t      side_in,
  input  logic [SumW-1:0] sum,
  output vpnt_side_t      side_out,
  output logic [LenW-1:0] len
);

  vpnt_side_t         sd [SqrtSteps+1];
  logic [RootInW-1:0] rv [SqrtSteps+1];
  logic [RootInW-1:0] rr [SqrtSteps+1];

  assign sd[0] = side_in;
  assign rv[0] = RootInW'({sum, SqrtPre'(0)});
  assign rr[0] = '0;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [RootInW-1:0] Bit = RootInW'(1) << (2 * (SqrtSteps - 1 - k));
    logic [RootInW-1:0] trial;
    logic               take;

    assign trial = rr[k] + Bit;
    assign take  = (rv[k] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k+1].valid <= 1'b0;
      end else if (en) begin
        sd[k+1] <= sd[k];
      end
      if (en) begin
        rv[k+1] <= take ? rv[k] - trial : rv[k];
        rr[k+1] <= take ? (rr[k] >> 1) + Bit : rr[k] >> 1;
      end
    end
  end

  assign side_out = sd[SqrtSteps];
  assign len      = rr[SqrtSteps][LenW-1:0];

endmodule

[hw/rtl/vpnt_div.sv]
// ----------------------------------------------------------------------------
// vpnt_div
// Three-lane restoring divide (|n|*2^26 + L) / 2L, one quotient bit per
// stage, then clamp, sign and the zero-normal substitute.
// ----------------------------------------------------------------------------
module vpnt_div import vpnt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  vpnt_side_t            side_in,
  input  logic [LenW-1:0]       len,
  output vpnt_side_t            side_out,
  output logic [2:0][UnitW-1:0] unit
);

  vpnt_side_t            sd [DivSteps+1];
  logic [DenW-1:0]       dd [DivSteps+1];
  logic [2:0][DenW-1:0]  rm [DivSteps+1];
  logic [2:0][QW-1:0]    lo [DivSteps+1];
  logic [2:0][QW-1:0]    qq [DivSteps+1];
  logic [2:0][NumW-1:0]  num;
  logic [2:0][QW-1:0]    qc;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num[l]   = (NumW'(side_in.mag[l]) << NumShift) + NumW'(len);
      rm[0][l] = DenW'(num[l][NumW-1:QW]);
      lo[0][l] = num[l][QW-1:0];
      qq[0][l] = '0;
    end
  end

  assign sd[0] = side_in;
  assign dd[0] = {len, 1'b0};

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [2:0][DenW:0] t;
    logic [2:0]         take;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]    = {rm[k][l], lo[k][l][QW-1]};
        take[l] = (t[l] >= {1'b0, dd[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k+1].valid <= 1'b0;
      end else if (en) begin
        sd[k+1] <= sd[k];
      end
      if (en) begin
        dd[k+1] <= dd[k];
        for (int l = 0; l < 3; l++) begin
          rm[k+1][l] <= take[l] ? DenW'(t[l] - {1'b0, dd[k]}) : DenW'(t[l]);
          lo[k+1][l] <= lo[k][l] << 1;
          qq[k+1][l] <= {qq[k][l][QW-2:0], take[l]};
        end
      end
    end
  end

  assign side_out = sd[DivSteps];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qc[l]   = (qq[DivSteps][l] > UnitOne) ? UnitOne : qq[DivSteps][l];
      unit[l] = sd[DivSteps].neg[l] ? UnitW'(-qc[l]) : qc[l];
    end
    if (sd[DivSteps].zero) begin
      unit[0] = '0;
      unit[1] = UnitOne;
      unit[2] = '0;
    end
  end

endmodule

[hw/rtl/vertex_point_normal_transform.sv]
// ----------------------------------------------------------------------------
// vertex_point_normal_transform
// Affine position transform plus normal transform and normalization.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                      | accepted when
//  ---------+-----+----------------------------------------------+---------------
//  vertex   | in  | pos_x/y/z (s16), norm_x/y/z (s16 Q1.14)      | valid & ready
//  result   | out | out_x/y/z (s24), unit_x/y/z (s16), degenerate | valid & ready
//  setup    | in  | index (3b), data (64b)                       | valid & ready
//
// One vertex request per cycle unless the result channel stalls; the pipe is the
// 32-stage square root (one root bit per stage) and the 16-stage divider
// (one quotient bit per stage) behind four multiply/sum stages.
// rst is synchronous and clears stage valid bits and loads identity matrices.
// The whole pipe advances when the last stage is empty or taken; a stall
// freezes every stage in place, so nothing is dropped or repeated.
// setup is always ready; writes land the next cycle.
// ----------------------------------------------------------------------------
module vertex_point_normal_transform import vpnt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  vpnt_in_if.sink    vertex,
  vpnt_out_if.source result,
  vpnt_cfg_if.sink   setup
);

  vpnt_cfg_t             cfg;
  vpnt_side_t            xf_side;
  logic [SumW-1:0]       xf_sum;
  vpnt_side_t            rt_side;
  logic [LenW-1:0]       rt_len;
  vpnt_side_t            dv_side;
  logic [2:0][UnitW-1:0] unit;
  logic                  adv;

  // global advance: last stage empty or being drained
  assign adv          = !dv_side.valid || result.ready;
  assign vertex.ready = adv;
  assign setup.ready  = 1'b1;

  vpnt_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (setup.valid),
    .index (setup.index),
    .data  (setup.data),
    .cfg   (cfg)
  );

  // products, rounding, translation, squared magnitude
  vpnt_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vertex.valid),
    .px       (vertex.pos_x),
    .py       (vertex.pos_y),
    .pz       (vertex.pos_z),
    .nx       (vertex.norm_x),
    .ny       (vertex.norm_y),
    .nz       (vertex.norm_z),
    .cfg      (cfg),
    .side     (xf_side),
    .sum      (xf_sum)
  );

  // length with 11 extra fraction bits
  vpnt_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .side_in  (xf_side),
    .sum      (xf_sum),
    .side_out (rt_side),
    .len      (rt_len)
  );

  // per-component divide, clamp, zero-normal fallback
  vpnt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .side_in  (rt_side),
    .len      (rt_len),
    .side_out (dv_side),
    .unit     (unit)
  );

  assign result.valid      = dv_side.valid;
  assign result.out_x      = dv_side.pos[0];
  assign result.out_y      = dv_side.pos[1];
  assign result.out_z      = dv_side.pos[2];
  assign result.unit_x     = unit[0];
  assign result.unit_y     = unit[1];
  assign result.unit_z     = unit[2];
  assign result.degenerate = dv_side.zero;

endmodule

[tb/tb_vertex_point_normal_transform.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_point_normal_transform
// Streams vertex requests through the affine position transform and normal
// normalization under several matrix settings. Results not in the directed
// table come from a built-in predictor; all are compared field by field in
// request order, with random idle cycles on both sides and a long result hold.
// ----------------------------------------------------------------------------
module tb_vertex_point_normal_transform;
  import vpnt_pkg::*;

  // indexes past the last register; the block must ignore writes there
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;
  localparam int LongHoldCycles = 300;
  localparam int DrainCycles    = 60;
  localparam int RandPerPhase   = 205;

  typedef struct {
    logic signed [15:0] px, py, pz, nx, ny, nz;
  } vertex_t;

  typedef struct {
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] ux, uy, uz;
    logic               degen;
  } xform_t;

  typedef struct {
    vertex_t v;
    bit      typed;   // expected value written into the table
    xform_t  exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vpnt_in_if  vin();
  vpnt_out_if vout();
  vpnt_cfg_if vcfg();

  vertex_point_normal_transform i_dut (
    .clk   (clk),
    .rst   (rst),
    .vertex(vin),
    .result(vout),
    .setup (vcfg)
  );

  always #5 clk = ~clk;

  // shadow of the matrix registers
  logic [63:0] point_mat [3];
  logic [47:0] normal_mat[3];

  xform_t pending_results[$];
  int     mismatches      = 0;
  int     send_gap_max    = 0;
  int     recv_stall_max  = 0;
  bit     long_hold_req   = 1'b0;

  function automatic longint coef(logic [63:0] word, int slot);
    logic signed [15:0] f;
    f = word[16*slot +: 16];
    return longint'(f);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned val);
    longint unsigned root, bit_w;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > val) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (val >= root + bit_w) begin
        val  = val - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // position: Q3.12 affine, round half up; normal: Q3.12 then unit length
  function automatic xform_t transform_vertex(vertex_t v);
    xform_t          r;
    longint          p[3], nin[3], n[3], acc, nacc, pos, u;
    longint unsigned sq, len, mag, q;
    p[0] = v.px; p[1] = v.py; p[2] = v.pz;
    nin[0] = v.nx; nin[1] = v.ny; nin[2] = v.nz;
    sq = 0;
    for (int row = 0; row < 3; row++) begin
      acc  = 0;
      nacc = 0;
      for (int c = 0; c < 3; c++) begin
        acc  += coef(point_mat[row], c) * p[c];
        nacc += coef({16'h0, normal_mat[row]}, c) * nin[c];
      end
      pos    = ((acc + 2048) >>> 12) + coef(point_mat[row], 3);
      n[row] = (nacc + 2048) >>> 12;
      mag    = (n[row] < 0) ? -n[row] : n[row];
      sq    += mag * mag;
      case (row)
        0: r.ox = pos[23:0];
        1: r.oy = pos[23:0];
        default: r.oz = pos[23:0];
      endcase
    end
    if (sq == 0) begin
      r.ux = 16'sd0; r.uy = 16'sd16384; r.uz = 16'sd0; r.degen = 1'b1;
      return r;
    end
    len = int_sqrt(sq << 22);
    for (int c = 0; c < 3; c++) begin
      mag = (n[c] < 0) ? -n[c] : n[c];
      q   = ((mag << 26) + len) / (2 * len);
      if (q > 16384) q = 16384;
      u = (n[c] < 0) ? -longint'(q) : longint'(q);
      case (c)
        0: r.ux = u[15:0];
        1: r.uy = u[15:0];
        default: r.uz = u[15:0];
      endcase
    end
    r.degen = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_vertex(vertex_t v, bit typed, xform_t exp);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vin.valid  <= 1'b1;
    vin.pos_x  <= v.px; vin.pos_y  <= v.py; vin.pos_z  <= v.pz;
    vin.norm_x <= v.nx; vin.norm_y <= v.ny; vin.norm_z <= v.nz;
    do @(posedge clk); while (!vin.ready);
    pending_results.push_back(typed ? exp : transform_vertex(v));
    @(negedge clk);
  endtask

  // only called with the pipe drained and the vertex channel idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    vcfg.valid <= 1'b1;
    vcfg.index <= idx;
    vcfg.data  <= data;
    do @(posedge clk); while (!vcfg.ready);
    if (idx < 3) point_mat[idx] = data;
    else if (idx < 6) normal_mat[idx - 3] = data[47:0];
    @(negedge clk);
    vcfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    vin.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_norm();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);          // beyond +-16384 too
      1:       return 16'sd0;
      2:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.px = 16'($urandom); v.py = 16'($urandom); v.pz = 16'($urandom);
    if ($urandom_range(0, 15) == 0) begin
      v.nx = 16'sd0; v.ny = 16'sd0; v.nz = 16'sd0;
    end else begin
      v.nx = pick_norm(); v.ny = pick_norm(); v.nz = pick_norm();
    end
    return v;
  endfunction

  task automatic random_phase(int count);
    xform_t none;
    none = '{default: '0};
    for (int i = 0; i < count; i++) begin
      // alternate stretches with and without idle cycles
      send_gap_max   = ((i / 40) % 2 == 0) ? 3 : 0;
      recv_stall_max = ((i / 50) % 2 == 0) ? 3 : 0;
      send_vertex(rand_vertex(), 1'b0, none);
    end
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // ------------------------------------------------------------- directed
  row_t dir_rows[$];

  function automatic void add_row(logic signed [15:0] px, py, pz, nx, ny, nz,
                                  bit typed, xform_t exp);
    row_t r;
    r.v     = '{px, py, pz, nx, ny, nz};
    r.typed = typed;
    r.exp   = exp;
    dir_rows.push_back(r);
  endfunction

  initial begin
    xform_t none;
    none = '{default: '0};
    vin.valid  = 1'b0;
    vin.pos_x  = '0; vin.pos_y  = '0; vin.pos_z  = '0;
    vin.norm_x = '0; vin.norm_y = '0; vin.norm_z = '0;
    vcfg.valid = 1'b0;
    vcfg.index = REG_POINT0;
    vcfg.data  = '0;
    point_mat[0]  = RowRst0; point_mat[1]  = RowRst1; point_mat[2]  = RowRst2;
    normal_mat[0] = RowRst0[47:0];
    normal_mat[1] = RowRst1[47:0];
    normal_mat[2] = RowRst2[47:0];

    // identity matrices after reset: position passes through
    add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1,
            '{24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0});
    add_row(16'sd32767, -16'sd32768, 16'sd1, 16'sd16384, 16'sd0, 16'sd0, 1,
            '{24'sd32767, -24'sd32768, 24'sd1, 16'sd16384, 16'sd0, 16'sd0, 1'b0});
    add_row(-16'sd32768, 16'sd32767, -16'sd1, 16'sd0, 16'sd0, -16'sd16384, 1,
            '{-24'sd32768, 24'sd32767, -24'sd1, 16'sd0, 16'sd0, -16'sd16384, 1'b0});
    // zero normal: up vector and flag, position still transformed
    add_row(16'sd100, -16'sd200, 16'sd300, 16'sd0, 16'sd0, 16'sd0, 1,
            '{24'sd100, -24'sd200, 24'sd300, 16'sd0, 16'sd16384, 16'sd0, 1'b1});
    add_row(16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1,
            '{24'sd0, 24'sd0, 24'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0});
    // diagonal, tiny and out-of-range normals go through the predictor
    add_row(16'sd5, 16'sd6, 16'sd7, 16'sd16384, 16'sd16384, 16'sd16384, 0, none);
    add_row(16'sd1, 16'sd1, 16'sd1, -16'sd16384, 16'sd16384, -16'sd16384, 0, none);
    add_row(16'sd2, 16'sd3, 16'sd4, 16'sd1, 16'sd0, 16'sd0, 0, none);
    add_row(16'sd9, 16'sd9, 16'sd9, 16'sd3, -16'sd4, 16'sd0, 0, none);
    add_row(-16'sd1, -16'sd1, -16'sd1, -16'sd32768, 16'sd32767, 16'sd0, 0, none);
    add_row(16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 16'sd32767, 0, none);
    add_row(16'sd0, 16'sd0, 16'sd0, -16'sd32768, -16'sd32768, -16'sd32768, 0, none);
    add_row(16'sd1234, 16'sd4321, -16'sd999, 16'sd11585, 16'sd11585, 16'sd0, 0, none);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].exp);
    random_phase(RandPerPhase);
    drain();

    // random matrices; writes to spare indexes must change nothing
    write_reg(REG_POINT0, rand_word());
    write_reg(REG_POINT1, rand_word());
    write_reg(REG_POINT2, rand_word());
    write_reg(REG_NORMAL0, rand_word());
    write_reg(REG_NORMAL1, rand_word());
    write_reg(REG_NORMAL2, rand_word());
    write_reg(RegSpare6, rand_word());
    write_reg(RegSpare7, rand_word());
    // receiver holds off while requests keep coming: pipe fills and stalls
    long_hold_req = 1'b1;
    random_phase(RandPerPhase);
    drain();

    // largest positive coefficients and translation
    write_reg(REG_POINT0, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_POINT1, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_POINT2, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_NORMAL0, 64'hFFFF_7FFF_7FFF_7FFF);
    write_reg(REG_NORMAL1, 64'h0000_7FFF_8000_7FFF);
    write_reg(REG_NORMAL2, 64'h0000_7FFF_7FFF_8000);
    random_phase(RandPerPhase);
    drain();

    // most negative everything
    for (int r = 0; r < 3; r++)
      write_reg(CfgIdxW'(REG_POINT0 + r), 64'h8000_8000_8000_8000);
    for (int r = 0; r < 3; r++)
      write_reg(CfgIdxW'(REG_NORMAL0 + r), 64'h0000_8000_8000_8000);
    random_phase(RandPerPhase);
    drain();

    // tiny normal matrix: normals come out small, and short ones round to zero and hit the flag
    for (int r = 0; r < 3; r++) write_reg(CfgIdxW'(REG_POINT0 + r), rand_word());
    write_reg(REG_NORMAL0, 64'h0000_0000_0000_0001);
    write_reg(REG_NORMAL1, 64'h0000_0000_0001_0000);
    write_reg(REG_NORMAL2, 64'h0000_FFFF_0000_0000);
    random_phase(RandPerPhase);
    drain();

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) $display("tb_vertex_point_normal_transform passed");
    else $display("tb_vertex_point_normal_transform failed");
    $finish;
  end

  // ------------------------------------------------------ result receiver
  initial begin
    int n;
    vout.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        vout.ready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk);
        long_hold_req = 1'b0;
      end
      n = $urandom_range(0, recv_stall_max);
      if (n > 0) begin
        vout.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      vout.ready <= 1'b1;
      do @(posedge clk); while (!vout.valid);
    end
  end

  // --------------------------------------------------------------- checker
  always @(posedge clk) begin
    xform_t e;
    if (!rst && vout.valid && vout.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (vout.out_x !== e.ox) begin
          $error("out_x exp %0d got %0d", e.ox, vout.out_x); mismatches++;
        end
        if (vout.out_y !== e.oy) begin
          $error("out_y exp %0d got %0d", e.oy, vout.out_y); mismatches++;
        end
        if (vout.out_z !== e.oz) begin
          $error("out_z exp %0d got %0d", e.oz, vout.out_z); mismatches++;
        end
        if (vout.unit_x !== e.ux) begin
          $error("unit_x exp %0d got %0d", e.ux, vout.unit_x); mismatches++;
        end
        if (vout.unit_y !== e.uy) begin
          $error("unit_y exp %0d got %0d", e.uy, vout.unit_y); mismatches++;
        end
        if (vout.unit_z !== e.uz) begin
          $error("unit_z exp %0d got %0d", e.uz, vout.unit_z); mismatches++;
        end
        if (vout.degenerate !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, vout.degenerate);
          mismatches++;
        end
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #5ms;
    $display("tb_vertex_point_normal_transform failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/vpnt_pkg.sv
hw/rtl/vpnt_in_if.sv
hw/rtl/vpnt_out_if.sv
hw/rtl/vpnt_cfg_if.sv
hw/rtl/vpnt_cfg_regs.sv
hw/rtl/vpnt_xform.sv
hw/rtl/vpnt_isqrt.sv
hw/rtl/vpnt_div.sv
hw/rtl/vertex_point_normal_transform.sv
tb/tb_vertex_point_normal_transform.sv
